[rtl/pru_pkg.sv]
// Shared types, constants and codes for the particle ring update core.
// Used by pru_ctrl, pru_dpath and particle_ring_update_core; depends on nothing.
`timescale 1ns / 1ps

package pru_pkg;

    // Sizes fixed by the field widths.
    localparam int unsigned MAX_PARTICLES_DEF = 64;
    localparam int unsigned SLOT_W            = 6;
    localparam int unsigned CNT_W             = 7;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned DATA_W            = 32;
    localparam int unsigned DIV_STEPS         = 32;
    localparam int unsigned MUL_STEPS         = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIFE_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_BIRTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DEATH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_BIRTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_DEATH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_Z     = 3'd7;

    // Result kinds.
    typedef enum logic [1:0] {
        K_STATE = 2'd0,
        K_SPAWN = 2'd1,
        K_FULL  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    // Steps of the shared multiplier for one particle.
    typedef enum logic [3:0] {
        M_TT, M_VX, M_VY, M_VZ, M_ALX, M_ALY, M_ALZ, M_AHX, M_AHY, M_AHZ,
        M_SIZE, M_CR0, M_CR1, M_CR2, M_CR3, M_SPIN
    } t_mstep;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE, OP_LATCH, OP_SPAWN, OP_READ, OP_AGE, OP_DIV, OP_MUL, OP_FIN, OP_END
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] addr;
        t_mstep            mstep;
        logic              full;
    } t_cmd;

    typedef struct packed {
        logic retire;
        logic out_free;
        logic pend_v;
    } t_stat;

    typedef struct packed {
        logic [31:0] life_time;
        logic [31:0] size_birth;
        logic [31:0] size_death;
        logic [31:0] col_birth;
        logic [31:0] col_death;
        logic [31:0] accel_x;
        logic [31:0] accel_y;
        logic [31:0] accel_z;
    } t_cfg;

    typedef struct packed {
        logic [31:0] time_step;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
        logic [31:0] speed_x;
        logic [31:0] speed_y;
        logic [31:0] speed_z;
        logic [31:0] spin_begin;
        logic [31:0] spin_end;
    } t_item;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       place_x;
        logic [31:0]       place_y;
        logic [31:0]       place_z;
        logic [31:0]       scale;
        logic [31:0]       tint;
        logic [31:0]       spin;
        logic              last;
    } t_result;

endpackage

[rtl/pru_ctrl.sv]
// Controller of the particle ring update core: sequencing state machine and ring pointers.
// Depends on pru_pkg; drives pru_dpath through command and status structs.
`timescale 1ns / 1ps

module pru_ctrl #(
    parameter int unsigned MAX_PARTICLES = pru_pkg::MAX_PARTICLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_action,
    output logic                       o_ready,
    input  pru_pkg::t_stat             i_stat,
    output pru_pkg::t_cmd              o_cmd,
    output logic [pru_pkg::CNT_W-1:0]  o_live
);

    typedef enum logic [3:0] {
        S_IDLE, S_SPAWN, S_READ, S_AGE, S_DIV, S_MUL, S_FIN, S_NEXT, S_END
    } t_state;

    localparam logic [pru_pkg::SLOT_W-1:0] LAST_SLOT = pru_pkg::SLOT_W'(MAX_PARTICLES - 1);
    localparam logic [pru_pkg::CNT_W-1:0]  MAX_CNT   = pru_pkg::CNT_W'(MAX_PARTICLES);

    t_state                      r_state;
    logic [pru_pkg::SLOT_W-1:0]  r_alive;
    logic [pru_pkg::SLOT_W-1:0]  r_dead;
    logic [pru_pkg::SLOT_W-1:0]  r_slot;
    logic [pru_pkg::CNT_W-1:0]   r_live;
    logic [pru_pkg::CNT_W-1:0]   r_k;
    logic [pru_pkg::CNT_W-1:0]   r_total;
    logic [4:0]                  r_cnt;
    logic                        w_full;

    function automatic logic [pru_pkg::SLOT_W-1:0] next_slot(
        input logic [pru_pkg::SLOT_W-1:0] s
    );
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign w_full  = (r_live >= MAX_CNT);
    assign o_ready = (r_state == S_IDLE);
    assign o_live  = r_live;

    // Command decode for the datapath.
    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = pru_pkg::OP_IDLE;
        o_cmd.mstep = pru_pkg::t_mstep'(r_cnt[3:0]);
        o_cmd.addr  = r_slot;
        o_cmd.full  = w_full;
        case (r_state)
            S_IDLE: begin
                if (i_valid) o_cmd.op = pru_pkg::OP_LATCH;
            end
            S_SPAWN: begin
                o_cmd.op   = pru_pkg::OP_SPAWN;
                o_cmd.addr = r_dead;
            end
            S_READ:  o_cmd.op = pru_pkg::OP_READ;
            S_AGE:   o_cmd.op = pru_pkg::OP_AGE;
            S_DIV:   o_cmd.op = pru_pkg::OP_DIV;
            S_MUL:   o_cmd.op = pru_pkg::OP_MUL;
            S_FIN:   o_cmd.op = pru_pkg::OP_FIN;
            S_END:   o_cmd.op = pru_pkg::OP_END;
            default: o_cmd.op = pru_pkg::OP_IDLE;
        endcase
    end

    // State, ring pointers and step counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_alive <= '0;
            r_dead  <= '0;
            r_live  <= '0;
            r_slot  <= '0;
            r_k     <= '0;
            r_total <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_action) begin
                            r_state <= S_SPAWN;
                        end else begin
                            r_total <= r_live;
                            r_k     <= '0;
                            r_slot  <= r_alive;
                            r_state <= (r_live == '0) ? S_END : S_READ;
                        end
                    end
                end
                S_SPAWN: begin
                    if (i_stat.out_free) begin
                        if (!w_full) begin
                            r_dead <= next_slot(r_dead);
                            r_live <= r_live + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_READ: r_state <= S_AGE;
                S_AGE: begin
                    r_cnt <= '0;
                    if (i_stat.retire) begin
                        r_alive <= next_slot(r_alive);
                        r_live  <= r_live - 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 5'(pru_pkg::DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(pru_pkg::MUL_STEPS - 1)) r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!i_stat.pend_v || i_stat.out_free) r_state <= S_NEXT;
                end
                S_NEXT: begin
                    r_slot  <= next_slot(r_slot);
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 == r_total) ? S_END : S_READ;
                end
                S_END: begin
                    if (i_stat.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/pru_dpath.sv]
// Datapath of the particle ring update core: slot memories, divider, shared multiplier,
// result assembly and the output register. Depends on pru_pkg; commanded by pru_ctrl.
`timescale 1ns / 1ps

module pru_dpath #(
    parameter int unsigned MAX_PARTICLES = pru_pkg::MAX_PARTICLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pru_pkg::t_cmd    i_cmd,
    input  pru_pkg::t_cfg    i_cfg,
    input  pru_pkg::t_item   i_item,
    input  logic             i_out_ready,
    output pru_pkg::t_stat   o_stat,
    output pru_pkg::t_result o_res,
    output logic             o_res_valid
);

    localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    // Slot memories.
    logic [31:0] m_age   [MAX_PARTICLES];
    logic [31:0] m_px    [MAX_PARTICLES];
    logic [31:0] m_py    [MAX_PARTICLES];
    logic [31:0] m_pz    [MAX_PARTICLES];
    logic [31:0] m_vx    [MAX_PARTICLES];
    logic [31:0] m_vy    [MAX_PARTICLES];
    logic [31:0] m_vz    [MAX_PARTICLES];
    logic [31:0] m_sfrom [MAX_PARTICLES];
    logic [31:0] m_sto   [MAX_PARTICLES];

    pru_pkg::t_item   r_item;
    logic [31:0]      r_rd_age;
    logic [31:0]      r_rd_p [3];
    logic [31:0]      r_rd_v [3];
    logic [31:0]      r_rd_sfrom;
    logic [31:0]      r_rd_sto;
    logic [31:0]      r_t;
    logic [31:0]      r_rem;
    logic [31:0]      r_q;
    logic [47:0]      r_tt;
    logic [48:0]      r_vq   [3];
    logic [55:0]      r_mlo  [3];
    logic [63:0]      r_aq   [3];
    logic [31:0]      r_size_step;
    logic [7:0]       r_cstep [4];
    logic [32:0]      r_spin_step;
    pru_pkg::t_result r_out;
    logic             r_out_v;
    pru_pkg::t_result r_pend;
    logic             r_pend_v;
    pru_pkg::t_result n_out;
    logic             n_out_v;
    pru_pkg::t_result n_pend;
    logic             n_pend_v;

    logic [AW-1:0]    w_idx;
    logic [32:0]      w_age_sum;
    logic [31:0]      w_t;
    logic [32:0]      w_dsh;
    logic [32:0]      w_dsub;
    logic             w_out_free;
    logic [31:0]      w_accel [3];
    logic [31:0]      w_vm [3];
    logic [31:0]      w_am [3];
    logic             w_vneg [3];
    logic             w_aneg [3];
    logic             w_size_up;
    logic [31:0]      w_size_mag;
    logic [32:0]      w_spin_d;
    logic             w_spin_up;
    logic [32:0]      w_spin_mag;
    logic [7:0]       w_cmag [4];
    logic             w_cup  [4];
    logic [32:0]      w_ma;
    logic [31:0]      w_mb;
    logic [64:0]      w_prod;
    logic signed [65:0] w_psum [3];
    logic [31:0]      w_place [3];
    pru_pkg::t_result w_new;
    pru_pkg::t_result w_spawn_res;

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 1'b1) : x;
    endfunction

    assign w_idx      = i_cmd.addr[AW-1:0];
    assign w_out_free = !r_out_v || i_out_ready;

    // Age update with saturation and the retire test.
    assign w_age_sum = {1'b0, r_rd_age} + {1'b0, r_item.time_step};
    assign w_t       = w_age_sum[32] ? '1 : w_age_sum[31:0];

    assign o_stat.retire   = (w_t >= i_cfg.life_time);
    assign o_stat.out_free = w_out_free;
    assign o_stat.pend_v   = r_pend_v;

    // Restoring divider step: one fraction bit of age / life_time a cycle.
    assign w_dsh  = {r_rem, 1'b0};
    assign w_dsub = w_dsh - {1'b0, i_cfg.life_time};

    // Latch the accepted input item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pru_pkg::OP_LATCH) r_item <= i_item;
    end

    // Memory writes: a full spawn record, or an age write-back during a tick.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pru_pkg::OP_SPAWN && w_out_free && !i_cmd.full) begin
            m_age[w_idx]   <= '0;
            m_px[w_idx]    <= r_item.origin_x;
            m_py[w_idx]    <= r_item.origin_y;
            m_pz[w_idx]    <= r_item.origin_z;
            m_vx[w_idx]    <= r_item.speed_x;
            m_vy[w_idx]    <= r_item.speed_y;
            m_vz[w_idx]    <= r_item.speed_z;
            m_sfrom[w_idx] <= r_item.spin_begin;
            m_sto[w_idx]   <= r_item.spin_end;
        end else if (i_cmd.op == pru_pkg::OP_AGE) begin
            m_age[w_idx] <= w_t;
        end
    end

    // Registered memory read of one slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pru_pkg::OP_READ) begin
            r_rd_age   <= m_age[w_idx];
            r_rd_p[0]  <= m_px[w_idx];
            r_rd_p[1]  <= m_py[w_idx];
            r_rd_p[2]  <= m_pz[w_idx];
            r_rd_v[0]  <= m_vx[w_idx];
            r_rd_v[1]  <= m_vy[w_idx];
            r_rd_v[2]  <= m_vz[w_idx];
            r_rd_sfrom <= m_sfrom[w_idx];
            r_rd_sto   <= m_sto[w_idx];
        end
    end

    // Divider registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pru_pkg::OP_AGE) begin
            r_t   <= w_t;
            r_rem <= w_t;
            r_q   <= '0;
        end else if (i_cmd.op == pru_pkg::OP_DIV) begin
            if (!w_dsub[32]) begin
                r_rem <= w_dsub[31:0];
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= w_dsh[31:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
    end

    // Magnitudes and directions of the operands.
    always_comb begin
        w_accel[0] = i_cfg.accel_x;
        w_accel[1] = i_cfg.accel_y;
        w_accel[2] = i_cfg.accel_z;
        for (int i = 0; i < 3; i++) begin
            w_vneg[i] = r_rd_v[i][31];
            w_aneg[i] = w_accel[i][31];
            w_vm[i]   = mag32(r_rd_v[i]);
            w_am[i]   = mag32(w_accel[i]);
        end
        for (int c = 0; c < 4; c++) begin
            w_cup[c]  = (i_cfg.col_death[8*c +: 8] >= i_cfg.col_birth[8*c +: 8]);
            w_cmag[c] = w_cup[c] ? (i_cfg.col_death[8*c +: 8] - i_cfg.col_birth[8*c +: 8])
                                 : (i_cfg.col_birth[8*c +: 8] - i_cfg.col_death[8*c +: 8]);
        end
    end

    assign w_size_up  = (i_cfg.size_death >= i_cfg.size_birth);
    assign w_size_mag = w_size_up ? (i_cfg.size_death - i_cfg.size_birth)
                                  : (i_cfg.size_birth - i_cfg.size_death);
    assign w_spin_d   = {r_rd_sto[31], r_rd_sto} - {r_rd_sfrom[31], r_rd_sfrom};
    assign w_spin_up  = !w_spin_d[32];
    assign w_spin_mag = w_spin_up ? w_spin_d : (~w_spin_d + 1'b1);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = r_q;
        case (i_cmd.mstep)
            pru_pkg::M_TT:   begin w_ma = {1'b0, r_t};     w_mb = r_t; end
            pru_pkg::M_VX:   begin w_ma = {1'b0, w_vm[0]}; w_mb = r_t; end
            pru_pkg::M_VY:   begin w_ma = {1'b0, w_vm[1]}; w_mb = r_t; end
            pru_pkg::M_VZ:   begin w_ma = {1'b0, w_vm[2]}; w_mb = r_t; end
            pru_pkg::M_ALX:  begin w_ma = {1'b0, w_am[0]}; w_mb = {8'd0, r_tt[23:0]}; end
            pru_pkg::M_ALY:  begin w_ma = {1'b0, w_am[1]}; w_mb = {8'd0, r_tt[23:0]}; end
            pru_pkg::M_ALZ:  begin w_ma = {1'b0, w_am[2]}; w_mb = {8'd0, r_tt[23:0]}; end
            pru_pkg::M_AHX:  begin w_ma = {1'b0, w_am[0]}; w_mb = {8'd0, r_tt[47:24]}; end
            pru_pkg::M_AHY:  begin w_ma = {1'b0, w_am[1]}; w_mb = {8'd0, r_tt[47:24]}; end
            pru_pkg::M_AHZ:  begin w_ma = {1'b0, w_am[2]}; w_mb = {8'd0, r_tt[47:24]}; end
            pru_pkg::M_SIZE: w_ma = {1'b0, w_size_mag};
            pru_pkg::M_CR0:  w_ma = {25'd0, w_cmag[0]};
            pru_pkg::M_CR1:  w_ma = {25'd0, w_cmag[1]};
            pru_pkg::M_CR2:  w_ma = {25'd0, w_cmag[2]};
            pru_pkg::M_CR3:  w_ma = {25'd0, w_cmag[3]};
            pru_pkg::M_SPIN: w_ma = w_spin_mag;
            default:         w_ma = '0;
        endcase
    end

    assign w_prod = {32'd0, w_ma} * {33'd0, w_mb};

    // Product registers, one per multiplier step. Negative terms round toward minus infinity.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pru_pkg::OP_MUL) begin
            case (i_cmd.mstep)
                pru_pkg::M_TT: r_tt <= w_prod[63:16];
                pru_pkg::M_VX: r_vq[0] <= w_prod[64:16] + 49'(w_vneg[0] && (w_prod[15:0] != '0));
                pru_pkg::M_VY: r_vq[1] <= w_prod[64:16] + 49'(w_vneg[1] && (w_prod[15:0] != '0));
                pru_pkg::M_VZ: r_vq[2] <= w_prod[64:16] + 49'(w_vneg[2] && (w_prod[15:0] != '0));
                pru_pkg::M_ALX: r_mlo[0] <= w_prod[55:0];
                pru_pkg::M_ALY: r_mlo[1] <= w_prod[55:0];
                pru_pkg::M_ALZ: r_mlo[2] <= w_prod[55:0];
                pru_pkg::M_AHX: r_aq[0] <= {w_prod[56:0], 7'd0} + 64'(r_mlo[0][55:17])
                                         + 64'(w_aneg[0] && (r_mlo[0][16:0] != '0));
                pru_pkg::M_AHY: r_aq[1] <= {w_prod[56:0], 7'd0} + 64'(r_mlo[1][55:17])
                                         + 64'(w_aneg[1] && (r_mlo[1][16:0] != '0));
                pru_pkg::M_AHZ: r_aq[2] <= {w_prod[56:0], 7'd0} + 64'(r_mlo[2][55:17])
                                         + 64'(w_aneg[2] && (r_mlo[2][16:0] != '0));
                pru_pkg::M_SIZE: r_size_step <= w_prod[63:32];
                pru_pkg::M_CR0:  r_cstep[0] <= w_prod[39:32];
                pru_pkg::M_CR1:  r_cstep[1] <= w_prod[39:32];
                pru_pkg::M_CR2:  r_cstep[2] <= w_prod[39:32];
                pru_pkg::M_CR3:  r_cstep[3] <= w_prod[39:32];
                pru_pkg::M_SPIN: r_spin_step <= w_prod[64:32];
                default: ;
            endcase
        end
    end

    // Assembly of one survivor's report: saturated positions and the lerps.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_psum[i] = $signed({{34{r_rd_p[i][31]}}, r_rd_p[i]})
                      + (w_vneg[i] ? -$signed({17'd0, r_vq[i]}) : $signed({17'd0, r_vq[i]}))
                      + (w_aneg[i] ? -$signed({2'd0, r_aq[i]}) : $signed({2'd0, r_aq[i]}));
            if (w_psum[i] > 66'sd2147483647)        w_place[i] = 32'h7FFF_FFFF;
            else if (w_psum[i] < -66'sd2147483648)  w_place[i] = 32'h8000_0000;
            else                                    w_place[i] = w_psum[i][31:0];
        end
        w_new         = '0;
        w_new.kind    = pru_pkg::K_STATE;
        w_new.slot    = i_cmd.addr;
        w_new.place_x = w_place[0];
        w_new.place_y = w_place[1];
        w_new.place_z = w_place[2];
        w_new.scale   = w_size_up ? (i_cfg.size_birth + r_size_step)
                                  : (i_cfg.size_birth - r_size_step);
        for (int c = 0; c < 4; c++) begin
            w_new.tint[8*c +: 8] = w_cup[c] ? (i_cfg.col_birth[8*c +: 8] + r_cstep[c])
                                            : (i_cfg.col_birth[8*c +: 8] - r_cstep[c]);
        end
        w_new.spin    = w_spin_up ? (r_rd_sfrom + r_spin_step[31:0])
                                  : (r_rd_sfrom - r_spin_step[31:0]);
        w_new.last    = 1'b0;
    end

    // Report of a spawn, or of a refused spawn when the ring is full.
    always_comb begin
        w_spawn_res      = '0;
        w_spawn_res.slot = i_cmd.addr;
        w_spawn_res.last = 1'b1;
        if (i_cmd.full) begin
            w_spawn_res.kind = pru_pkg::K_FULL;
        end else begin
            w_spawn_res.kind    = pru_pkg::K_SPAWN;
            w_spawn_res.place_x = r_item.origin_x;
            w_spawn_res.place_y = r_item.origin_y;
            w_spawn_res.place_z = r_item.origin_z;
            w_spawn_res.scale   = i_cfg.size_birth;
            w_spawn_res.tint    = i_cfg.col_birth;
            w_spawn_res.spin    = r_item.spin_begin;
        end
    end

    // Next values of the output register and of the one-deep hold that waits to learn
    // which report is last.
    always_comb begin
        n_out    = r_out;
        n_out_v  = r_out_v && !i_out_ready;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        case (i_cmd.op)
            pru_pkg::OP_SPAWN: begin
                if (w_out_free) begin
                    n_out   = w_spawn_res;
                    n_out_v = 1'b1;
                end
            end
            pru_pkg::OP_FIN: begin
                if (!r_pend_v) begin
                    n_pend   = w_new;
                    n_pend_v = 1'b1;
                end else if (w_out_free) begin
                    n_out   = r_pend;
                    n_out_v = 1'b1;
                    n_pend  = w_new;
                end
            end
            pru_pkg::OP_END: begin
                if (w_out_free) begin
                    n_out_v = 1'b1;
                    if (r_pend_v) begin
                        n_out = r_pend;
                    end else begin
                        n_out      = '0;
                        n_out.kind = pru_pkg::K_NONE;
                    end
                    n_out.last = 1'b1;
                    n_pend_v   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Output register and hold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_pend_v <= n_pend_v;
        end
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_v;

endmodule

[rtl/particle_ring_update_core.sv]
// Particle ring update core: configuration registers, controller and datapath.
// The core takes one item at a time and is not ready while it works on one. A tick
// reads and ages each live particle; a survivor also passes through the fraction divider
// and the 16 shared multiplier steps, and a stalled output holds the core until it is taken.
// Reset (synchronous, active low) empties the ring and loads the register defaults.
`timescale 1ns / 1ps

module particle_ring_update_core #(
    parameter int unsigned MAX_PARTICLES = pru_pkg::MAX_PARTICLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pru_pkg::DATA_W-1:0]      i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_action,
    input  logic [31:0]                     i_time_step,
    input  logic signed [31:0]              i_origin_x,
    input  logic signed [31:0]              i_origin_y,
    input  logic signed [31:0]              i_origin_z,
    input  logic signed [31:0]              i_speed_x,
    input  logic signed [31:0]              i_speed_y,
    input  logic signed [31:0]              i_speed_z,
    input  logic signed [31:0]              i_spin_begin,
    input  logic signed [31:0]              i_spin_end,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_kind,
    output logic [pru_pkg::SLOT_W-1:0]      o_slot,
    output logic signed [31:0]              o_place_x,
    output logic signed [31:0]              o_place_y,
    output logic signed [31:0]              o_place_z,
    output logic [31:0]                     o_scale,
    output logic [31:0]                     o_tint,
    output logic signed [31:0]              o_spin,
    output logic                            o_last
);

    pru_pkg::t_cfg     r_cfg;
    pru_pkg::t_item    w_item;
    pru_pkg::t_cmd     w_cmd;
    pru_pkg::t_stat    w_stat;
    pru_pkg::t_result  w_res;
    logic [pru_pkg::CNT_W-1:0] w_live;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.life_time  <= 32'h0001_0000;
            r_cfg.size_birth <= 32'h0001_0000;
            r_cfg.size_death <= '0;
            r_cfg.col_birth  <= 32'hFFFF_FFFF;
            r_cfg.col_death  <= '0;
            r_cfg.accel_x    <= '0;
            r_cfg.accel_y    <= '0;
            r_cfg.accel_z    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pru_pkg::CFG_LIFE_TIME:  r_cfg.life_time  <= i_cfg_data;
                pru_pkg::CFG_SIZE_BIRTH: r_cfg.size_birth <= i_cfg_data;
                pru_pkg::CFG_SIZE_DEATH: r_cfg.size_death <= i_cfg_data;
                pru_pkg::CFG_COL_BIRTH:  r_cfg.col_birth  <= i_cfg_data;
                pru_pkg::CFG_COL_DEATH:  r_cfg.col_death  <= i_cfg_data;
                pru_pkg::CFG_ACCEL_X:    r_cfg.accel_x    <= i_cfg_data;
                pru_pkg::CFG_ACCEL_Y:    r_cfg.accel_y    <= i_cfg_data;
                pru_pkg::CFG_ACCEL_Z:    r_cfg.accel_z    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input item bundle.
    always_comb begin
        w_item.time_step  = i_time_step;
        w_item.origin_x   = i_origin_x;
        w_item.origin_y   = i_origin_y;
        w_item.origin_z   = i_origin_z;
        w_item.speed_x    = i_speed_x;
        w_item.speed_y    = i_speed_y;
        w_item.speed_z    = i_speed_z;
        w_item.spin_begin = i_spin_begin;
        w_item.spin_end   = i_spin_end;
    end

    pru_ctrl #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_live   (w_live)
    );

    pru_dpath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_item      (w_item),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_res_valid (o_valid)
    );

    assign o_kind    = w_res.kind;
    assign o_slot    = w_res.slot;
    assign o_place_x = w_res.place_x;
    assign o_place_y = w_res.place_y;
    assign o_place_z = w_res.place_z;
    assign o_scale   = w_res.scale;
    assign o_tint    = w_res.tint;
    assign o_spin    = w_res.spin;
    assign o_last    = w_res.last;

    // The ring never holds more particles than it has slots.
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_live <= pru_pkg::CNT_W'(MAX_PARTICLES))
        else $error("live count exceeds ring size");

    // Once an item is taken the core is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken again without processing");

    // A spawn report, taken or refused, or an empty tick is always the only report of its item.
    a_single_reports_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == pru_pkg::K_FULL || o_kind == pru_pkg::K_NONE
                     || o_kind == pru_pkg::K_SPAWN)) |-> o_last)
        else $error("single report without last flag");

endmodule
